// ----- src/aes_pkg.sv -----
// shared types, constants and functions for the aes block cipher
package aes_pkg;

    localparam int BlockWidth   = 128;
    localparam int CfgDataWidth = 64;
    localparam int CfgIdxWidth  = 3;
    localparam int NumCfgRegs   = 5;
    localparam int KeyStoreDepth = 60;

    localparam logic [CfgIdxWidth-1:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_KEY_WORD_0 = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_KEY_WORD_1 = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_KEY_WORD_2 = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_KEY_WORD_3 = 3'd4;

    localparam logic [1:0] KEY_LEN_128 = 2'd0;
    localparam logic [1:0] KEY_LEN_192 = 2'd1;
    localparam logic [1:0] KEY_LEN_256 = 2'd2;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_FIRST,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load_block;
        logic       key_seed;
        logic       key_step;
        logic [5:0] key_waddr;
        logic       key_we;
        logic [5:0] key_raddr;
        logic       do_first;
        logic       do_round;
        logic       last_round;
        logic       out_load;
    } aes_cmd_t;

    typedef struct packed {
        logic out_valid;
    } aes_status_t;

    function automatic logic [7:0] xt(input logic [7:0] x);
        xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = t[x];
    endfunction

    function automatic logic [7:0] sbox_rev(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        sbox_rev = t[x];
    endfunction

endpackage

// ----- src/aes_word_if.sv -----
// valid/ready channel carrying one word
interface aes_word_if #(
    parameter int Width = 129
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/aes_ram.sv -----
// generic single-port-write ram with registered read
module aes_ram #(
    parameter int Width = 32,
    parameter int Depth = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/aes_ctrl.sv -----
// controller: key expansion sequencing and round sequencing
module aes_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            key_len,
    input  logic                  in_valid,
    input  logic                  in_op,
    output logic                  in_ready,
    input  logic                  out_ready,
    input  aes_pkg::aes_status_t  status,
    output aes_pkg::aes_cmd_t     cmd,
    output logic                  busy
);
    aes_pkg::aes_state_t state_reg, state_next;
    logic       sched_ok_reg, sched_ok_next;
    logic [5:0] idx_reg, idx_next;
    logic [3:0] rnd_reg, rnd_next;
    logic       op_reg, op_next;
    logic [5:0] total;
    logic [3:0] nr;

    always_comb
    begin
        case (key_len)
            aes_pkg::KEY_LEN_128: nr = 4'd10;
            aes_pkg::KEY_LEN_192: nr = 4'd12;
            default:              nr = 4'd14;
        endcase
        total = {nr, 2'b00} + 6'd4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= aes_pkg::ST_IDLE;
            sched_ok_reg <= 1'b0;
            idx_reg      <= '0;
            rnd_reg      <= '0;
            op_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sched_ok_reg <= sched_ok_next;
            idx_reg      <= idx_next;
            rnd_reg      <= rnd_next;
            op_reg       <= op_next;
        end
    end

    // key address for round r
    function automatic logic [5:0] kaddr(input logic [3:0] r, input logic [1:0] c);
        kaddr = {r, c};
    endfunction

    always_comb
    begin
        state_next    = state_reg;
        sched_ok_next = sched_ok_reg;
        idx_next      = idx_reg;
        rnd_next      = rnd_reg;
        op_next       = op_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        busy          = (state_reg != aes_pkg::ST_IDLE);
        case (state_reg)
            aes_pkg::ST_IDLE:
            begin
                if (!cfg_write)
                begin
                    if (!sched_ok_reg)
                    begin
                        state_next = aes_pkg::ST_EXPAND;
                        idx_next   = '0;
                        cmd.key_seed = 1'b1;
                    end
                    else
                    begin
                        in_ready = 1'b1;
                        if (in_valid)
                        begin
                            cmd.load_block = 1'b1;
                            op_next  = in_op;
                            rnd_next = (in_op == aes_pkg::OP_DECRYPT) ? nr : 4'd0;
                            idx_next = '0;
                            state_next = aes_pkg::ST_LOAD;
                        end
                    end
                end
            end
            aes_pkg::ST_EXPAND:
            begin
                // one schedule word per cycle, written from the datapath's window
                cmd.key_we    = 1'b1;
                cmd.key_waddr = idx_reg;
                cmd.key_step  = 1'b1;
                idx_next = idx_reg + 6'd1;
                if (idx_reg == total - 6'd1)
                begin
                    sched_ok_next = 1'b1;
                    state_next    = aes_pkg::ST_IDLE;
                end
            end
            aes_pkg::ST_LOAD:
            begin
                // fetch the four words of the current round key, one per cycle
                cmd.key_raddr = kaddr(rnd_reg, idx_reg[1:0]);
                idx_next = idx_reg + 6'd1;
                if (idx_reg[1:0] == 2'd3)
                begin
                    idx_next   = '0;
                    state_next = aes_pkg::ST_ROUND;
                end
            end
            aes_pkg::ST_ROUND:
            begin
                // key words arrive registered; last one lands this cycle
                if (rnd_reg == ((op_reg == aes_pkg::OP_DECRYPT) ? nr : 4'd0))
                begin
                    cmd.do_first = 1'b1;
                end
                else
                begin
                    cmd.do_round   = 1'b1;
                    cmd.last_round = (op_reg == aes_pkg::OP_DECRYPT) ?
                                     (rnd_reg == 4'd0) : (rnd_reg == nr);
                end
                if (cmd.last_round)
                begin
                    state_next = aes_pkg::ST_DONE;
                end
                else
                begin
                    rnd_next   = (op_reg == aes_pkg::OP_DECRYPT) ? rnd_reg - 4'd1
                                                                 : rnd_reg + 4'd1;
                    state_next = aes_pkg::ST_LOAD;
                end
            end
            aes_pkg::ST_DONE:
            begin
                // output register free, or its word leaves this cycle
                if (!status.out_valid || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = aes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = aes_pkg::ST_IDLE;
            end
        endcase
        if (cfg_write)
        begin
            sched_ok_next = 1'b0;
            // a key write during expansion restarts it
            if (state_reg == aes_pkg::ST_EXPAND)
            begin
                state_next = aes_pkg::ST_IDLE;
            end
        end
    end
endmodule

// ----- src/aes_datapath.sv -----
// datapath: key expansion window, round key store, round logic and output register
module aes_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aes_pkg::aes_cmd_t     cmd,
    input  logic                  op,
    input  logic [1:0]            key_len,
    input  logic [255:0]          key,
    input  logic [127:0]          block,
    input  logic                  out_ready,
    output aes_pkg::aes_status_t  status,
    output logic [127:0]          result
);
    logic [255:0] win_reg;       // last eight schedule words, newest at bottom
    logic [3:0]   cnt_reg;       // position within nk
    logic [7:0]   rc_reg;
    logic [5:0]   widx_reg;
    logic [127:0] st_reg;
    logic [127:0] rk_reg;
    logic         op_reg;
    logic         out_valid_reg;
    logic [127:0] res_reg;
    logic [31:0]  rdata;
    logic [31:0]  new_word;
    logic [3:0]   nk;

    always_comb
    begin
        case (key_len)
            aes_pkg::KEY_LEN_128: nk = 4'd4;
            aes_pkg::KEY_LEN_192: nk = 4'd6;
            default:              nk = 4'd8;
        endcase
    end

    // schedule word generation
    always_comb
    begin
        logic [31:0] t, back;
        t    = win_reg[31:0];
        back = win_reg[32*nk-1 -: 32];
        if (cnt_reg == 4'd0)
        begin
            t = {aes_pkg::sbox(t[23:16]), aes_pkg::sbox(t[15:8]),
                 aes_pkg::sbox(t[7:0]),   aes_pkg::sbox(t[31:24])} ^ {rc_reg, 24'h0};
        end
        else if (nk == 4'd8 && cnt_reg == 4'd4)
        begin
            t = {aes_pkg::sbox(t[31:24]), aes_pkg::sbox(t[23:16]),
                 aes_pkg::sbox(t[15:8]),  aes_pkg::sbox(t[7:0])};
        end
        if (widx_reg < {2'b00, nk})
        begin
            new_word = key[255 - 32*widx_reg[2:0] -: 32];
        end
        else
        begin
            new_word = back ^ t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_seed)
        begin
            widx_reg <= '0;
            cnt_reg  <= '0;
            rc_reg   <= 8'h01;
        end
        else if (cmd.key_step)
        begin
            win_reg  <= {win_reg[223:0], new_word};
            widx_reg <= widx_reg + 6'd1;
            if (widx_reg >= {2'b00, nk})
            begin
                if (cnt_reg == 4'd0)
                begin
                    rc_reg <= aes_pkg::xt(rc_reg);
                end
                cnt_reg <= (cnt_reg == nk - 4'd1) ? 4'd0 : cnt_reg + 4'd1;
            end
        end
    end

    aes_ram #(.Width(32), .Depth(aes_pkg::KeyStoreDepth)) u_store (
        .clk   (clk),
        .we    (cmd.key_we),
        .waddr (cmd.key_waddr),
        .wdata (new_word),
        .raddr (cmd.key_raddr),
        .rdata (rdata)
    );

    // round logic
    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] a2, a4, a8;
        a2 = aes_pkg::xt(a);
        a4 = aes_pkg::xt(a2);
        a8 = aes_pkg::xt(a4);
        gm = (b[0] ? a : 8'h0) ^ (b[1] ? a2 : 8'h0) ^ (b[2] ? a4 : 8'h0) ^ (b[3] ? a8 : 8'h0);
    endfunction

    logic [127:0] round_out;
    logic [127:0] rk_full;
    always_comb
    begin
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] m [16];
        logic [127:0] o;
        rk_full = {rk_reg[95:0], rdata};
        for (int i = 0; i < 16; i++)
        begin
            s[i] = st_reg[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (op_reg == aes_pkg::OP_DECRYPT)
                begin
                    t[((c + r) % 4) * 4 + r] = aes_pkg::sbox_rev(s[c*4 + r]);
                end
                else
                begin
                    t[c*4 + r] = aes_pkg::sbox(s[((c + r) % 4) * 4 + r]);
                end
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            o[127 - 8*i -: 8] = t[i];
        end
        if (op_reg == aes_pkg::OP_DECRYPT)
        begin
            o = o ^ rk_full;
        end
        for (int i = 0; i < 16; i++)
        begin
            t[i] = o[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (op_reg == aes_pkg::OP_DECRYPT)
                begin
                    m[c*4+r] = gm(t[c*4+r], 4'he) ^ gm(t[c*4+(r+1)%4], 4'hb) ^
                               gm(t[c*4+(r+2)%4], 4'hd) ^ gm(t[c*4+(r+3)%4], 4'h9);
                end
                else
                begin
                    m[c*4+r] = gm(t[c*4+r], 4'h2) ^ gm(t[c*4+(r+1)%4], 4'h3) ^
                               t[c*4+(r+2)%4] ^ t[c*4+(r+3)%4];
                end
            end
        end
        if (cmd.last_round)
        begin
            round_out = o;
        end
        else
        begin
            for (int i = 0; i < 16; i++)
            begin
                round_out[127 - 8*i -: 8] = m[i];
            end
        end
        if (op_reg != aes_pkg::OP_DECRYPT)
        begin
            round_out = round_out ^ rk_full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_block)
        begin
            st_reg <= block;
            op_reg <= op;
        end
        else if (cmd.do_first)
        begin
            st_reg <= st_reg ^ rk_full;
        end
        else if (cmd.do_round)
        begin
            st_reg <= round_out;
        end
        // shift in the key word read last cycle
        rk_reg  <= rk_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg <= st_reg;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign result = res_reg;
endmodule

// ----- src/aes_block_cipher.sv -----
// top level of the aes block cipher
// each key addition is four key reads and one round step; nr+1 additions, then the output load,
//   lie between input word and result word
// a new word is taken only after the previous result is loaded; the one-word-a-cycle key store read sets the pace
// after reset or any key write the schedule is rebuilt before input opens
// reset clears the control state and selects a 128-bit all-zero key; the key store has no reset
module aes_block_cipher (
    input  logic                              clk,
    input  logic                              rst_n,
    aes_word_if.sink                          in_ch,
    aes_word_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [aes_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  logic [aes_pkg::CfgDataWidth-1:0]  cfg_data
);
    // configuration registers
    logic [1:0]   key_len_reg;
    logic [255:0] key_reg;
    logic         cfg_hit;

    assign cfg_hit = cfg_we && (cfg_index < aes_pkg::CfgIdxWidth'(aes_pkg::NumCfgRegs));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= aes_pkg::KEY_LEN_128;
            key_reg     <= '0;
        end
        else if (cfg_hit)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_LENGTH:
                    // unused length code maps to 256-bit
                    key_len_reg <= (cfg_data[1:0] == 2'd3) ? aes_pkg::KEY_LEN_256 : cfg_data[1:0];
                aes_pkg::REG_KEY_WORD_0: key_reg[255:192] <= cfg_data;
                aes_pkg::REG_KEY_WORD_1: key_reg[191:128] <= cfg_data;
                aes_pkg::REG_KEY_WORD_2: key_reg[127:64]  <= cfg_data;
                aes_pkg::REG_KEY_WORD_3: key_reg[63:0]    <= cfg_data;
                default: key_reg <= key_reg;
            endcase
        end
    end

    aes_pkg::aes_cmd_t    cmd;
    aes_pkg::aes_status_t status;
    logic                 busy;
    logic                 in_ready;

    // controller: expansion then round sequencing
    aes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_hit),
        .key_len   (key_len_reg),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.data[128]),
        .in_ready  (in_ready),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // datapath: schedule window, key store, one round a step
    aes_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (in_ch.data[128]),
        .key_len   (key_len_reg),
        .key       (key_reg),
        .block     (in_ch.data[127:0]),
        .out_ready (out_ch.ready),
        .status    (status),
        .result    (out_ch.data)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = status.out_valid;

    // a stalled result keeps its word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result changed while stalled");

    // a result only follows a finished block
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(cmd.out_load))
        else $error("result without completion");

    // input only opens while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !busy)
        else $error("input ready while busy");
endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the aes block cipher: directed vectors, then random words
module tb;
    import aes_pkg::*;

    // key settings used by the directed table
    typedef enum logic [2:0] {
        KS_RESET,       // no write at all, reset key
        KS_STD_128,     // standard 128-bit example key
        KS_STRAY,       // writes to unused register indexes only
        KS_STD_192,
        KS_STD_256,
        KS_ONES_CODE3,  // unused length code, all-ones key
        KS_ONES_128
    } key_set_t;

    typedef struct packed {
        key_set_t     key_set;
        logic         op;
        logic [127:0] blk;
        logic         known;     // result typed in below
        logic [127:0] result;
    } dir_row_t;

    localparam logic [127:0] STD_PT   = 128'h00112233445566778899aabbccddeeff;
    localparam logic [127:0] CT_128   = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
    localparam logic [127:0] CT_192   = 128'hdda97ca4864cdfe06eaf70a0ec0d7191;
    localparam logic [127:0] CT_256   = 128'h8ea2b7ca516745bfeafc49904b496089;
    localparam logic [127:0] ZERO_CT  = 128'h66e94bd4ef8a2c3b884cfa59ca342b2e;
    localparam logic [127:0] ALL_ONES = {128{1'b1}};
    localparam int NumDirected = 16;
    localparam int NumPhases   = 7;
    localparam int PhaseItems  = 250;
    localparam int DrainCycles = 90;
    localparam longint CycleLimit = 1500000;

    localparam dir_row_t DIRECTED [NumDirected] = '{
        '{KS_RESET,      OP_ENCRYPT, '0,       1'b1, ZERO_CT},
        '{KS_RESET,      OP_DECRYPT, ZERO_CT,  1'b1, '0},
        '{KS_RESET,      OP_ENCRYPT, ALL_ONES, 1'b0, '0},
        '{KS_STD_128,    OP_ENCRYPT, STD_PT,   1'b1, CT_128},
        '{KS_STD_128,    OP_DECRYPT, CT_128,   1'b1, STD_PT},
        '{KS_STD_128,    OP_DECRYPT, ALL_ONES, 1'b0, '0},
        '{KS_STRAY,      OP_ENCRYPT, STD_PT,   1'b1, CT_128},
        '{KS_STD_192,    OP_ENCRYPT, STD_PT,   1'b1, CT_192},
        '{KS_STD_192,    OP_DECRYPT, CT_192,   1'b1, STD_PT},
        '{KS_STD_256,    OP_ENCRYPT, STD_PT,   1'b1, CT_256},
        '{KS_STD_256,    OP_DECRYPT, CT_256,   1'b1, STD_PT},
        '{KS_ONES_CODE3, OP_ENCRYPT, '0,       1'b0, '0},
        '{KS_ONES_CODE3, OP_DECRYPT, ALL_ONES, 1'b0, '0},
        '{KS_ONES_CODE3, OP_ENCRYPT, ALL_ONES, 1'b0, '0},
        '{KS_ONES_128,   OP_ENCRYPT, ALL_ONES, 1'b0, '0},
        '{KS_ONES_128,   OP_DECRYPT, '0,       1'b0, '0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CfgIdxWidth-1:0]  cfg_index;
    logic [CfgDataWidth-1:0] cfg_data;

    // input word is {op, block}, result word is the block
    aes_word_if #(.Width(BlockWidth + 1)) in_ch ();
    aes_word_if #(.Width(BlockWidth))     out_ch ();

    aes_block_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [7:0]  fwd_sub [256];
    logic [7:0]  inv_sub [256];
    logic [1:0]  cur_key_len;
    logic [63:0] cur_key [4];
    logic [31:0] sched_words [60];
    logic [127:0] pending_blocks [$];
    int  errors;
    bit  calm;      // no idling on either side while set
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= a;
            a = xtime(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
        logic [15:0] d;
        d = {v, v} << n;
        return d[15:8];
    endfunction

    // substitution tables built from the field inverse walk, not copied
    function automatic void build_sub_tables();
        logic [7:0] p, q;
        p = 8'h01;
        q = 8'h01;
        do
        begin
            p = p ^ xtime(p);
            q ^= q << 1;
            q ^= q << 2;
            q ^= q << 4;
            if (q[7])
                q ^= 8'h09;
            fwd_sub[p] = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ 8'h63;
        end
        while (p != 8'h01);
        fwd_sub[0] = 8'h63;
        for (int i = 0; i < 256; i++)
            inv_sub[fwd_sub[i]] = i[7:0];
    endfunction

    function automatic int key_words();
        return cur_key_len == KEY_LEN_128 ? 4 : (cur_key_len == KEY_LEN_192 ? 6 : 8);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {fwd_sub[w[31:24]], fwd_sub[w[23:16]], fwd_sub[w[15:8]], fwd_sub[w[7:0]]};
    endfunction

    function automatic void expand_keys();
        int nk;
        logic [7:0] rcon;
        logic [31:0] t;
        logic [63:0] kw;
        nk = key_words();
        rcon = 8'h01;
        for (int i = 0; i < nk; i++)
        begin
            kw = cur_key[(i >> 1) & 3];
            sched_words[i] = i[0] ? kw[31:0] : kw[63:32];
        end
        for (int i = nk; i < 4 * (nk + 7) && i < 60; i++)
        begin
            t = sched_words[i-1];
            if (i % nk == 0)
            begin
                t = sub_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
                rcon = xtime(rcon);
            end
            else if (nk == 8 && i % nk == 4)
                t = sub_word(t);
            sched_words[i] = sched_words[i-nk] ^ t;
        end
    endfunction

    // predicted result of one block under the current schedule
    function automatic logic [127:0] cipher_block(input logic op, input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] col [4];
        logic [7:0] coef [4];
        logic [31:0] w;
        logic [7:0] acc;
        logic [127:0] res;
        int nr, rnd;
        nr = key_words() + 6;
        for (int i = 0; i < 16; i++)
            s[i] = blk[127 - 8*i -: 8];
        if (op == OP_DECRYPT)
            coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        else
            coef = '{8'h02, 8'h03, 8'h01, 8'h01};
        for (int step = 0; step <= nr; step++)
        begin
            rnd = (op == OP_DECRYPT) ? nr - step : step;
            if (step > 0)
            begin
                // byte substitution with row shift
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        if (op == OP_DECRYPT)
                            t[((c + r) & 3) * 4 + r] = inv_sub[s[c*4 + r]];
                        else
                            t[c*4 + r] = fwd_sub[s[((c + r) & 3) * 4 + r]];
                s = t;
            end
            // forward mixes before the key, inverse after it
            for (int pass = 0; pass < 2; pass++)
            begin
                if (pass == 0 && op == OP_DECRYPT || pass == 1 && op == OP_ENCRYPT)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        w = sched_words[(rnd * 4 + c) % 60];
                        for (int r = 0; r < 4; r++)
                            s[4*c + r] ^= w[31 - 8*r -: 8];
                    end
                end
                else if (step > 0 && step < nr)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        for (int k = 0; k < 4; k++)
                            col[k] = s[4*c + k];
                        for (int r = 0; r < 4; r++)
                        begin
                            acc = '0;
                            for (int k = 0; k < 4; k++)
                                acc ^= gf_mul(col[k], coef[(k + 4 - r) & 3]);
                            s[4*c + r] = acc;
                        end
                    end
                end
            end
        end
        for (int i = 0; i < 16; i++)
            res[127 - 8*i -: 8] = s[i];
        return res;
    endfunction

    function automatic bit idle_now();
        return !calm && $urandom_range(99) < 29;
    endfunction

    // one register write, tracked by the predictor
    task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_KEY_LENGTH)
            cur_key_len = (val[1:0] == 2'd3) ? KEY_LEN_256 : val[1:0];
        else if (idx < NumCfgRegs)
            cur_key[idx - 1] = val;
        expand_keys();
    endtask

    task automatic load_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3);
        write_reg(REG_KEY_LENGTH, {62'h0, len});
        write_reg(REG_KEY_WORD_0, k0);
        write_reg(REG_KEY_WORD_1, k1);
        write_reg(REG_KEY_WORD_2, k2);
        write_reg(REG_KEY_WORD_3, k3);
    endtask

    // key writes only with nothing in flight
    task automatic wait_drained();
        wait (pending_blocks.size() == 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // present one word from a falling edge, return at a falling edge after acceptance
    task automatic send_block(input logic op, input logic [127:0] blk,
                              input bit known, input logic [127:0] result);
        while (idle_now())
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = {op, blk};
        do
            @(posedge clk);
        while (!in_ch.ready);
        pending_blocks.push_back(known ? result : cipher_block(op, blk));
        @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [127:0] rand_block();
        case ($urandom_range(15))
            0: return '0;
            1: return ALL_ONES;
            default: return {rand64(), rand64()};
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin
        logic [127:0] want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                $error("out_ch word with nothing expected: %h", out_ch.data);
                errors++;
            end
            else
            begin
                want = pending_blocks.pop_front();
                if (out_ch.data[127:64] !== want[127:64])
                begin
                    $error("out_high expected %h actual %h", want[127:64], out_ch.data[127:64]);
                    errors++;
                end
                if (out_ch.data[63:0] !== want[63:0])
                begin
                    $error("out_low expected %h actual %h", want[63:0], out_ch.data[63:0]);
                    errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ch.ready <= rst_n && !idle_now();
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        key_set_t last_set;
        logic [1:0] len;
        errors       = 0;
        cycles       = 0;
        calm         = 1'b0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        build_sub_tables();
        cur_key_len = KEY_LEN_128;
        cur_key     = '{default: '0};
        expand_keys();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, key changes between rows
        last_set = KS_RESET;
        for (int i = 0; i < NumDirected; i++)
        begin
            if (DIRECTED[i].key_set != last_set)
            begin
                in_ch.valid = 1'b0;
                wait_drained();
                case (DIRECTED[i].key_set)
                    KS_STD_128:
                        load_key(KEY_LEN_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                 '0, '0);
                    KS_STRAY:
                        for (int idx = NumCfgRegs; idx < 2**CfgIdxWidth; idx++)
                            write_reg(idx[CfgIdxWidth-1:0], rand64());
                    KS_STD_192:
                        load_key(KEY_LEN_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                 64'h1011121314151617, '0);
                    KS_STD_256:
                        load_key(KEY_LEN_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
                    KS_ONES_CODE3:
                        load_key(2'd3, '1, '1, '1, '1);
                    default:
                        load_key(KEY_LEN_128, '1, '1, '1, '1);
                endcase
                last_set = DIRECTED[i].key_set;
            end
            send_block(DIRECTED[i].op, DIRECTED[i].blk, DIRECTED[i].known, DIRECTED[i].result);
        end

        // random phases, each under a new key
        for (int ph = 0; ph < NumPhases; ph++)
        begin
            in_ch.valid = 1'b0;
            wait_drained();
            len = (ph < 4) ? ph[1:0] : 2'($urandom_range(3));
            if (ph == 4)
                load_key(len, '0, '0, '0, '0);
            else if (ph == 5)
                load_key(len, '1, '1, '1, '1);
            else
                load_key(len, rand64(), rand64(), rand64(), rand64());
            if (ph == 6)
                write_reg(CfgIdxWidth'(NumCfgRegs), rand64());
            calm = (ph == 3);
            for (int n = 0; n < PhaseItems; n++)
                send_block(1'($urandom), rand_block(), 1'b0, '0);
            calm = 1'b0;
        end
        in_ch.valid = 1'b0;

        wait (pending_blocks.size() == 0);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
